// ===== src/smdr_pkg.sv =====
// package: widths, register indexes, stage codes and tables for the stepper sequencer
package smdr_pkg;

  localparam int SampleW   = 8;
  localparam int CoilW     = 4;
  localparam int StageW    = 2;
  localparam int StepsW    = 9;
  localparam int TicksW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int NumBins   = 5;
  localparam int BinIdxW   = 3;
  localparam int PhaseW    = 2;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] REG_STEP_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP_GAP   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DWELL_BIN0 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DWELL_BIN4 = 3'd6;

  // reset values of the registers
  localparam logic [StepsW-1:0] STEP_COUNT_RST = 9'd416;
  localparam logic [TicksW-1:0] STEP_GAP_RST   = 16'd50;
  localparam logic [TicksW-1:0] DWELL_RST [NumBins] =
    '{16'd4000, 16'd8000, 16'd16000, 16'd24000, 16'd40000};

  // sample bin bounds
  localparam logic [SampleW-1:0] BIN_BOUND1 = 8'd51;
  localparam logic [SampleW-1:0] BIN_BOUND2 = 8'd102;
  localparam logic [SampleW-1:0] BIN_BOUND3 = 8'd153;
  localparam logic [SampleW-1:0] BIN_BOUND4 = 8'd204;

  // stage codes on the result
  localparam logic [StageW-1:0] STAGE_IDLE  = 2'd0;
  localparam logic [StageW-1:0] STAGE_FWD   = 2'd1;
  localparam logic [StageW-1:0] STAGE_DWELL = 2'd2;
  localparam logic [StageW-1:0] STAGE_REV   = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_FWD   = 4'b0010,
    MODE_DWELL = 4'b0100,
    MODE_REV   = 4'b1000
  } mode_t;

  // wave drive coil pattern per phase, bits 1a,1b,2a,2b
  function automatic logic [CoilW-1:0] coil_of_phase(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] c;
    unique case (ph)
      2'd0: c = 4'b1000;
      2'd1: c = 4'b0001;
      2'd2: c = 4'b0100;
      2'd3: c = 4'b0010;
      default: c = 4'b0000;
    endcase
    return c;
  endfunction

  function automatic logic [BinIdxW-1:0] bin_of(input logic [SampleW-1:0] s);
    logic [BinIdxW-1:0] b;
    if (s < BIN_BOUND1) b = 3'd0;
    else if (s < BIN_BOUND2) b = 3'd1;
    else if (s < BIN_BOUND3) b = 3'd2;
    else if (s < BIN_BOUND4) b = 3'd3;
    else b = 3'd4;
    return b;
  endfunction

endpackage

// ===== src/smdr_in_if.sv =====
// interface: tick channel carrying start request and sensor sample
interface smdr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_request;
  logic [smdr_pkg::SampleW-1:0]  sensor_sample;

  modport source (output valid, start_request, sensor_sample, input ready);
  modport sink   (input valid, start_request, sensor_sample, output ready);
endinterface

// ===== src/smdr_out_if.sv =====
// interface: result channel carrying coil pattern, busy flag and stage
interface smdr_out_if;
  logic                         valid;
  logic                         ready;
  logic [smdr_pkg::CoilW-1:0]   coil_drive;
  logic                         busy_res;
  logic [smdr_pkg::StageW-1:0]  stage;

  modport source (output valid, coil_drive, busy_res, stage, input ready);
  modport sink   (input valid, coil_drive, busy_res, stage, output ready);
endinterface

// ===== src/smdr_cfg_if.sv =====
// interface: register write channel with index and data
interface smdr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [smdr_pkg::CfgIdxW-1:0]   index;
  logic [smdr_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/stepper_move_dwell_return_unit.sv =====
// top level: stepper move, dwell and return sequencer with wave drive output
// a result is valid in the cycle after its tick transfer
// throughput: one tick per cycle unless a held result stalls it; the state update
//   is a single pass from the state registers into the result register, the skid stage
// reset (rst, synchronous): idle, coils off, counters cleared, registers at
//   their default values, no result pending
module stepper_move_dwell_return_unit (
  input logic       clk,
  input logic       rst,
  smdr_in_if.sink   item,
  smdr_out_if.source result,
  smdr_cfg_if.sink  cfg
);
  import smdr_pkg::*;

  // state of a stepping stage
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CoilW-1:0]  pattern;
    logic [StepsW-1:0] steps;
    logic [TicksW-1:0] ticks;
  } step_state_t;

  // one tick of a stepping stage: step on the first tick of a gap
  function automatic step_state_t step_tick(input step_state_t s, input logic cw,
                                            input logic [TicksW-1:0] gap_reg);
    step_state_t       r;
    logic [TicksW-1:0] gap;
    r   = s;
    gap = (gap_reg == '0) ? TicksW'(1) : gap_reg;
    if (s.ticks == '0 && s.steps != '0) begin
      r.phase   = cw ? (s.phase - PhaseW'(1)) : (s.phase + PhaseW'(1));
      r.pattern = coil_of_phase(r.phase);
      r.steps   = s.steps - StepsW'(1);
      r.ticks   = gap - TicksW'(1);
    end else if (s.ticks != '0) begin
      r.ticks = s.ticks - TicksW'(1);
    end
    return r;
  endfunction

  // configuration registers
  logic [StepsW-1:0] step_count;
  logic [TicksW-1:0] step_gap;
  logic [TicksW-1:0] dwell_bin [NumBins];

  // sequencer state
  mode_t             mode, mode_next;
  logic [PhaseW-1:0] phase_index, phase_index_next;
  logic [StepsW-1:0] steps_left, steps_left_next;
  logic [TicksW-1:0] ticks_left, ticks_left_next;
  logic [TicksW-1:0] dwell_chosen, dwell_chosen_next;
  logic [CoilW-1:0]  drive_pattern, drive_pattern_next;
  logic [StageW-1:0] stage_next;

  logic item_xfer;

  // result register doubles as skid: a new tick goes in when the slot frees up
  assign item.ready = !result.valid || result.ready;
  assign item_xfer  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // register writes, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_COUNT_RST;
      step_gap   <= STEP_GAP_RST;
      for (int i = 0; i < NumBins; i++) dwell_bin[i] <= DWELL_RST[i];
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_STEP_COUNT) begin
        step_count <= cfg.data[StepsW-1:0];
      end else if (cfg.index == REG_STEP_GAP) begin
        step_gap <= cfg.data;
      end else if (cfg.index >= REG_DWELL_BIN0 && cfg.index <= REG_DWELL_BIN4) begin
        dwell_bin[BinIdxW'(cfg.index - REG_DWELL_BIN0)] <= cfg.data;
      end
    end
  end

  // next state for one tick
  always_comb begin
    step_state_t s;
    mode_t       m;
    logic        done;
    m = mode;
    s.phase   = phase_index;
    s.pattern = drive_pattern;
    s.steps   = steps_left;
    s.ticks   = ticks_left;
    dwell_chosen_next = dwell_chosen;
    done = 1'b0;

    // idle with a request: latch the dwell of the sample's bin and start forward
    if (m == MODE_IDLE && item.start_request) begin
      dwell_chosen_next = dwell_bin[bin_of(item.sensor_sample)];
      s.steps = step_count;
      s.ticks = '0;
      m = MODE_FWD;
    end

    unique case (m)
      MODE_FWD: begin
        s    = step_tick(s, 1'b1, step_gap);
        done = (s.ticks == '0) && (s.steps == '0);
        if (done) begin
          if (dwell_chosen_next == '0) begin
            // zero dwell skips straight to reverse
            m       = MODE_REV;
            s.steps = step_count;
            s.ticks = '0;
          end else begin
            m       = MODE_DWELL;
            s.ticks = dwell_chosen_next;
          end
        end
      end
      MODE_DWELL: begin
        if (s.ticks != '0) s.ticks = s.ticks - TicksW'(1);
        if (s.ticks == '0) begin
          m       = MODE_REV;
          s.steps = step_count;
          s.ticks = '0;
        end
      end
      MODE_REV: begin
        s    = step_tick(s, 1'b0, step_gap);
        done = (s.ticks == '0) && (s.steps == '0);
        if (done) m = MODE_IDLE;
      end
      MODE_IDLE: begin
        m = MODE_IDLE;
      end
      default: begin
        m = MODE_IDLE;
      end
    endcase

    mode_next          = m;
    phase_index_next   = s.phase;
    drive_pattern_next = s.pattern;
    steps_left_next    = s.steps;
    ticks_left_next    = s.ticks;

    unique case (m)
      MODE_IDLE:  stage_next = STAGE_IDLE;
      MODE_FWD:   stage_next = STAGE_FWD;
      MODE_DWELL: stage_next = STAGE_DWELL;
      MODE_REV:   stage_next = STAGE_REV;
      default:    stage_next = STAGE_IDLE;
    endcase
  end

  // state advances on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      phase_index   <= '0;
      steps_left    <= '0;
      ticks_left    <= '0;
      dwell_chosen  <= '0;
      drive_pattern <= '0;
    end else if (item_xfer) begin
      mode          <= mode_next;
      phase_index   <= phase_index_next;
      steps_left    <= steps_left_next;
      ticks_left    <= ticks_left_next;
      dwell_chosen  <= dwell_chosen_next;
      drive_pattern <= drive_pattern_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (item_xfer) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      result.coil_drive <= drive_pattern_next;
      result.busy_res   <= (mode_next != MODE_IDLE);
      result.stage      <= stage_next;
    end
  end

`ifndef NO_ASSERTIONS
  // every tick transfer leaves a result waiting
  a_result_after_tick: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> result.valid)
    else $error("no result after tick transfer");

  // wave drive energizes at most one coil
  a_single_coil: assert property (@(posedge clk) disable iff (rst)
    $onehot0(drive_pattern))
    else $error("more than one coil energized");

  // forward stage has used up all its steps before the dwell
  a_dwell_no_steps: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DWELL |-> steps_left == '0)
    else $error("steps left during dwell");

  // idle leaves no counts behind
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> (steps_left == '0 && ticks_left == '0))
    else $error("counters not cleared in idle");
`endif

endmodule

// ===== verif/stepper_move_dwell_return_unit_tb.sv =====
// testbench: stepper move/dwell/return sequencer, checked tick by tick against a local predictor
module stepper_move_dwell_return_unit_tb;
  import smdr_pkg::*;

  // spare register index, writes to it must change nothing
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;
  // generous bound on the whole run, in time units (clock period is 4)
  localparam int TimeoutTime = 8_000_000;
  // cycles let pass after the last result before a register write
  localparam int SettleCycles = 2;
  // normal idling, in cycles of a hundred
  localparam int IdlePct = 34;
  // sample values on both sides of every bin bound
  localparam logic [SampleW-1:0] EDGE_SAMPLES [10] =
    '{8'd0, 8'd50, 8'd51, 8'd101, 8'd102, 8'd152, 8'd153, 8'd203, 8'd204, 8'd255};
  // wave drive coil pattern per phase, bits 1a,1b,2a,2b
  localparam logic [CoilW-1:0] WAVE_COIL [4] = '{4'b1000, 4'b0001, 4'b0100, 4'b0010};

  typedef struct packed {
    logic               start;
    logic [SampleW-1:0] smp;
  } tick_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  typedef struct packed {
    logic [CoilW-1:0]  coil;
    logic              busy;
    logic [StageW-1:0] stage;
  } coil_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smdr_in_if  tick_if ();
  smdr_out_if res_if ();
  smdr_cfg_if reg_if ();

  stepper_move_dwell_return_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (tick_if),
    .result (res_if),
    .cfg    (reg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending stimulus, filled by the sequencer and drained by the driver
  tick_t      tick_q [$];
  reg_write_t reg_q [$];
  // predicted results, oldest first
  coil_res_t  coil_expect_q [$];

  int idle_pct = IdlePct;
  int ticks_queued = 0;
  int ticks_accepted = 0;
  int regs_queued = 0;
  int regs_done = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycles_done = 0;
  int starts_seen = 0;

  // transfer flags seen at the last rising edge, used by the driver
  logic tick_taken = 1'b0;
  logic reg_taken = 1'b0;

  // predictor copy of the registers
  logic [StepsW-1:0] reg_steps;
  logic [TicksW-1:0] reg_gap;
  logic [TicksW-1:0] reg_dwell [NumBins];

  // predictor copy of the sequencer state
  mode_t             seq_mode;
  logic [PhaseW-1:0] seq_phase;
  logic [StepsW-1:0] seq_steps;
  logic [TicksW-1:0] seq_ticks;
  logic [TicksW-1:0] seq_dwell;
  logic [CoilW-1:0]  seq_coil;

  task automatic report_mismatch(input string what);
    // print only the first few, keep counting the rest
    if (mismatch_count < 40) $display("mismatch at result %0d: %s", results_checked, what);
    mismatch_count++;
  endtask

  function automatic void reset_predictor();
    reg_steps = STEP_COUNT_RST;
    reg_gap   = STEP_GAP_RST;
    for (int b = 0; b < NumBins; b++) reg_dwell[b] = DWELL_RST[b];
    seq_mode  = MODE_IDLE;
    seq_phase = '0;
    seq_steps = '0;
    seq_ticks = '0;
    seq_dwell = '0;
    seq_coil  = '0;
  endfunction

  function automatic int sample_bin(input logic [SampleW-1:0] smp);
    if (smp < BIN_BOUND1) return 0;
    if (smp < BIN_BOUND2) return 1;
    if (smp < BIN_BOUND3) return 2;
    if (smp < BIN_BOUND4) return 3;
    return 4;
  endfunction

  function automatic void enter_reverse();
    seq_mode  = MODE_REV;
    seq_steps = reg_steps;
    seq_ticks = '0;
  endfunction

  // one tick of a stepping stage, 1 once the last gap has run out
  function automatic logic stepping_tick(input logic clockwise);
    logic [TicksW-1:0] gap;
    gap = (reg_gap == '0) ? 16'd1 : reg_gap;
    if (seq_ticks == '0 && seq_steps != '0) begin
      // clockwise walks the phases downward, counter-clockwise upward
      seq_phase = clockwise ? seq_phase - 2'd1 : seq_phase + 2'd1;
      seq_coil  = WAVE_COIL[seq_phase];
      seq_steps = seq_steps - 9'd1;
      seq_ticks = gap - 16'd1;
    end else if (seq_ticks != '0) begin
      seq_ticks = seq_ticks - 16'd1;
    end
    return seq_ticks == '0 && seq_steps == '0;
  endfunction

  function automatic logic [StageW-1:0] stage_code(input mode_t m);
    case (m)
      MODE_FWD:   return STAGE_FWD;
      MODE_DWELL: return STAGE_DWELL;
      MODE_REV:   return STAGE_REV;
      default:    return STAGE_IDLE;
    endcase
  endfunction

  // advance the sequencer by one tick and give the result it reports
  function automatic coil_res_t sequencer_tick(input tick_t t);
    coil_res_t r;
    // a request is only seen while idle, it also makes the first step at once
    if (seq_mode == MODE_IDLE && t.start) begin
      seq_dwell = reg_dwell[sample_bin(t.smp)];
      seq_steps = reg_steps;
      seq_ticks = '0;
      seq_mode  = MODE_FWD;
      starts_seen++;
    end
    case (seq_mode)
      MODE_FWD: begin
        if (stepping_tick(1'b1)) begin
          // a zero dwell goes straight to the return
          if (seq_dwell == '0) begin
            enter_reverse();
          end else begin
            seq_mode  = MODE_DWELL;
            seq_ticks = seq_dwell;
          end
        end
      end
      MODE_DWELL: begin
        if (seq_ticks != '0) seq_ticks = seq_ticks - 16'd1;
        if (seq_ticks == '0) enter_reverse();
      end
      MODE_REV: begin
        // the tick that ends the return already reports idle
        if (stepping_tick(1'b0)) begin
          seq_mode = MODE_IDLE;
          cycles_done++;
        end
      end
      default: ;
    endcase
    r.coil  = seq_coil;
    r.busy  = (seq_mode != MODE_IDLE);
    r.stage = stage_code(seq_mode);
    return r;
  endfunction

  function automatic void apply_reg_write(input reg_write_t w);
    // step count keeps only its low 9 bits, the spare index is dropped
    if (w.index == REG_STEP_COUNT) reg_steps = w.data[StepsW-1:0];
    else if (w.index == REG_STEP_GAP) reg_gap = w.data;
    else if (w.index >= REG_DWELL_BIN0 && w.index <= REG_DWELL_BIN4)
      reg_dwell[w.index - REG_DWELL_BIN0] = w.data;
  endfunction

  // driver: all inputs change on the falling edge
  always @(negedge clk) begin : driver
    tick_t      t;
    reg_write_t w;
    if (rst) begin
      tick_if.valid <= 1'b0;
      res_if.ready  <= 1'b0;
      reg_if.valid  <= 1'b0;
    end else begin
      // a new tick only once the held one has been taken
      if (!tick_if.valid || tick_taken) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          t = tick_q.pop_front();
          tick_if.valid         <= 1'b1;
          tick_if.start_request <= t.start;
          tick_if.sensor_sample <= t.smp;
        end else begin
          // idle cycle, payload is noise
          tick_if.valid         <= 1'b0;
          tick_if.start_request <= 1'($urandom_range(1));
          tick_if.sensor_sample <= SampleW'($urandom);
        end
      end
      res_if.ready <= ($urandom_range(99) >= idle_pct);
      if (!reg_if.valid || reg_taken) begin
        if (reg_q.size() != 0) begin
          w = reg_q.pop_front();
          reg_if.valid <= 1'b1;
          reg_if.index <= w.index;
          reg_if.data  <= w.data;
        end else begin
          reg_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: results are checked before the tick of the same edge is predicted
  always @(posedge clk) begin : monitor
    coil_res_t  want;
    tick_t      t;
    reg_write_t w;
    if (rst) begin
      tick_taken <= 1'b0;
      reg_taken  <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (coil_expect_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = coil_expect_q.pop_front();
          if (res_if.coil_drive !== want.coil)
            report_mismatch($sformatf("coil_drive got %b want %b", res_if.coil_drive, want.coil));
          if (res_if.busy_res !== want.busy)
            report_mismatch($sformatf("busy_res got %b want %b", res_if.busy_res, want.busy));
          if (res_if.stage !== want.stage)
            report_mismatch($sformatf("stage got %0d want %0d", res_if.stage, want.stage));
        end
        results_checked++;
      end
      tick_taken <= tick_if.valid && tick_if.ready;
      if (tick_if.valid && tick_if.ready) begin
        t.start = tick_if.start_request;
        t.smp   = tick_if.sensor_sample;
        coil_expect_q.push_back(sequencer_tick(t));
        ticks_accepted++;
      end
      reg_taken <= reg_if.valid && reg_if.ready;
      if (reg_if.valid && reg_if.ready) begin
        w.index = reg_if.index;
        w.data  = reg_if.data;
        apply_reg_write(w);
        regs_done++;
      end
    end
  end

  task automatic push_tick(input logic req, input logic [SampleW-1:0] smp);
    tick_t t;
    t.start = req;
    t.smp   = smp;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  // random ticks, requests in req_pct of a hundred
  task automatic feed_ticks(input int n, input int req_pct);
    for (int i = 0; i < n; i++) begin
      while (tick_q.size() >= 8) @(posedge clk);
      push_tick($urandom_range(99) < req_pct, SampleW'($urandom));
    end
  endtask

  // sender holds off until every tick is in and every result is out
  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || coil_expect_q.size() != 0) @(posedge clk);
  endtask

  // plain ticks until the running move/dwell/return is over
  task automatic finish_cycle();
    while (!(seq_mode == MODE_IDLE && ticks_accepted == ticks_queued)) begin
      if (tick_q.size() == 0 && seq_mode != MODE_IDLE) push_tick(1'b0, SampleW'($urandom));
      @(posedge clk);
    end
  endtask

  // register write, only with nothing in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    reg_write_t w;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    w.index = idx;
    w.data  = val;
    reg_q.push_back(w);
    regs_queued++;
    while (regs_done != regs_queued) @(posedge clk);
  endtask

  task automatic write_dwells(input logic [CfgDataW-1:0] d0, input logic [CfgDataW-1:0] d1,
                              input logic [CfgDataW-1:0] d2, input logic [CfgDataW-1:0] d3,
                              input logic [CfgDataW-1:0] d4);
    write_reg(REG_DWELL_BIN0, d0);
    write_reg(REG_DWELL_BIN0 + CfgIdxW'(1), d1);
    write_reg(REG_DWELL_BIN0 + CfgIdxW'(2), d2);
    write_reg(REG_DWELL_BIN0 + CfgIdxW'(3), d3);
    write_reg(REG_DWELL_BIN4, d4);
  endtask

  initial begin : sequencer
    tick_if.valid         = 1'b0;
    tick_if.start_request = 1'b0;
    tick_if.sensor_sample = '0;
    res_if.ready          = 1'b0;
    reg_if.valid          = 1'b0;
    reg_if.index          = '0;
    reg_if.data           = '0;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // coils stay off before the first step
    push_tick(1'b0, 8'd255);
    push_tick(1'b0, 8'd0);
    // short move at the reset gap, lowest bin, requests while busy are dropped
    write_reg(REG_STEP_COUNT, 16'd3);
    write_reg(REG_DWELL_BIN0, 16'd12);
    push_tick(1'b1, 8'd0);
    push_tick(1'b1, 8'd255);
    push_tick(1'b1, 8'd128);
    feed_ticks(60, 50);
    // shorten the gap mid-move, it is picked up at the next step
    write_reg(REG_STEP_GAP, 16'd1);
    finish_cycle();

    // one step, one tick per step, a distinct dwell per bin
    write_reg(REG_STEP_COUNT, 16'd1);
    write_dwells(16'd0, 16'd1, 16'd2, 16'd3, 16'd4);
    write_reg(REG_SPARE, CfgDataW'($urandom));
    foreach (EDGE_SAMPLES[k]) begin
      push_tick(1'b1, EDGE_SAMPLES[k]);
      finish_cycle();
    end

    // request held on every tick, a new cycle starts right after each return
    write_reg(REG_STEP_COUNT, 16'd2);
    for (int i = 0; i < 14; i++) push_tick(1'b1, SampleW'($urandom));
    finish_cycle();

    // zero gap behaves as one tick per step
    write_reg(REG_STEP_GAP, 16'd0);
    push_tick(1'b1, 8'd180);
    finish_cycle();

    // zero step count through the masked upper data bits
    write_reg(REG_STEP_COUNT, 16'hFE00);
    push_tick(1'b1, 8'd0);
    finish_cycle();
    push_tick(1'b1, 8'd60);
    finish_cycle();

    // random phases with small settings, registers also land mid-cycle
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_STEP_COUNT, {7'($urandom), 9'($urandom_range(0, 4))});
      write_reg(REG_STEP_GAP, 16'($urandom_range(0, 3)));
      write_dwells(16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                   16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                   16'($urandom_range(0, 10)));
      if ($urandom_range(1)) write_reg(REG_SPARE, CfgDataW'($urandom));
      feed_ticks(36, 35);
      wait_drained();
      feed_ticks(36, 35);
    end
    finish_cycle();

    // most steps and longest gap, all data bits set, run without any idling;
    // the run ends inside this move
    idle_pct = 0;
    write_reg(REG_STEP_COUNT, 16'hFFFF);
    write_reg(REG_STEP_GAP, 16'hFFFF);
    push_tick(1'b1, 8'd255);
    feed_ticks(100, 50);

    wait_drained();
    repeat (4) @(posedge clk);
    if (coil_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", coil_expect_q.size()));
    $display("covered %0d ticks, %0d results checked, %0d register writes",
             ticks_accepted, results_checked, regs_done);
    $display("%0d cycles started, %0d completed, incl. bin edges, zero gap/count/dwell, longest gap",
             starts_seen, cycles_done);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TimeoutTime;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
src/smdr_pkg.sv
src/smdr_in_if.sv
src/smdr_out_if.sv
src/smdr_cfg_if.sv
src/stepper_move_dwell_return_unit.sv
verif/stepper_move_dwell_return_unit_tb.sv
